### rtl/bar_pkg.sv
// Package with the shared types and constants of the button auto-repeat block.
package bar_pkg;

    // Number of button lanes that are updated; mask bits above it always read as zero.
    localparam int NUM_BUTTONS = 32;
    localparam int MASK_W      = 32;
    localparam int TICK_W      = 32;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE   = 2'd0,
        CFG_DELAY    = 2'd1,
        CFG_INTERVAL = 2'd2
    } t_cfg_reg;

    // One poll transaction on the input channel.
    typedef struct packed {
        logic [MASK_W-1:0] press_edges;
        logic [MASK_W-1:0] held_bits;
        logic [MASK_W-1:0] release_edges;
        logic [TICK_W-1:0] now_ticks;
        logic              any_read;
    } t_bar_in;

    // One result transaction on the output channel.
    typedef struct packed {
        logic [MASK_W-1:0] pressed_mask;
        logic [MASK_W-1:0] held_mask;
        logic [MASK_W-1:0] released_mask;
        logic              status;
    } t_bar_out;

    // Input bits of one button for one poll.
    typedef struct packed {
        logic press;
        logic held;
        logic rel;
    } t_lane_in;

    // Reported flags of one button.
    typedef struct packed {
        logic pressed;
        logic held;
        logic released;
    } t_lane_flags;

endpackage

### rtl/bar_lane.sv
// One button lane: reported flags, repeat state and last press or pulse time of a single button.
module bar_lane import bar_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_en_flip,
    input  t_lane_in          i_in,
    input  logic              i_enable,
    input  logic [TICK_W-1:0] i_now,
    input  logic [TICK_W-1:0] i_delay,
    input  logic [TICK_W-1:0] i_interval,
    output t_lane_flags       o_next
);

    t_lane_flags       r_flags, n_flags;
    logic              r_pulse, n_pulse;
    logic              r_waiting, n_waiting;
    logic [TICK_W-1:0] r_last, n_last;
    logic [TICK_W-1:0] since;
    logic              wait_now;

    // Time since the last press or pulse, modulo the tick width.
    assign since    = i_now - r_last;
    assign wait_now = r_waiting && !(since > i_delay);

    // Per-button update: press edge first, then held, then release edge.
    always_comb begin
        n_flags   = r_flags;
        n_pulse   = r_pulse;
        n_waiting = r_waiting;
        n_last    = r_last;
        if (i_in.press) begin
            n_flags = '{pressed: 1'b1, held: 1'b0, released: 1'b0};
            n_pulse = 1'b0;
            n_last  = i_now;
        end else if (i_in.held) begin
            if (i_enable) begin
                n_flags.pressed = 1'b0;
                n_flags.held    = 1'b0;
                if (r_pulse) begin
                    // The poll after a repeat pulse reports the matching release.
                    n_flags.released = 1'b1;
                    n_pulse          = 1'b0;
                end else begin
                    n_waiting = wait_now;
                    if (!wait_now && (since > i_interval)) begin
                        n_flags.pressed  = 1'b1;
                        n_flags.released = 1'b0;
                        n_last           = i_now;
                        n_pulse          = 1'b1;
                    end
                end
            end else begin
                n_flags = '{pressed: 1'b0, held: 1'b1, released: 1'b0};
            end
        end else if (i_in.rel) begin
            n_flags   = '{pressed: 1'b0, held: 1'b0, released: 1'b1};
            n_waiting = 1'b1;
        end
    end

    assign o_next = i_step ? n_flags : r_flags;

    // Lane state; a change of the enable bit while the lane does not step re-arms the first-repeat wait.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags   <= '0;
            r_pulse   <= 1'b0;
            r_waiting <= 1'b1;
            r_last    <= '0;
        end else if (i_step) begin
            r_flags   <= n_flags;
            r_pulse   <= n_pulse;
            r_waiting <= n_waiting;
            r_last    <= n_last;
        end else if (i_en_flip) begin
            r_pulse   <= 1'b0;
            r_waiting <= 1'b1;
        end
    end

endmodule

### rtl/button_auto_repeat.sv
// Top level of the button auto-repeat block: config registers, pipeline control and lanes.
//
// The block takes one poll transaction per clock cycle while its input side is not stalled
// and returns one result transaction per poll. A poll is first captured in an
// input register; from there every button lane computes its new flags in
// parallel, and the result lands in the output register once that register is
// free. One 32-bit subtract and two compares per lane set the cycle time.
// Both registers advance together, so a full output register that is not taken
// stalls the input side only after the input register has filled.
// A poll with any_read low leaves all state alone and returns the current flags
// with status set. Configuration writes take effect at once and must be made
// while no poll is in flight; changing a button's enable bit cancels a pending
// repeat release and re-arms the first-repeat wait. No clearing pass is needed
// after reset.
module button_auto_repeat import bar_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_bar_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_bar_out             o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [MASK_W-1:0] r_enable;
    logic [TICK_W-1:0] r_delay;
    logic [TICK_W-1:0] r_interval;
    logic [MASK_W-1:0] en_flip;
    logic              enable_we;

    logic              r_in_vld;
    t_bar_in           r_in;
    logic              r_out_vld;
    t_bar_out          r_out;
    logic              advance;
    logic              step;

    t_lane_flags       lane_next [MASK_W];
    logic [MASK_W-1:0] n_pressed;
    logic [MASK_W-1:0] n_held;
    logic [MASK_W-1:0] n_released;

    // Configuration register decode.
    always_comb begin
        enable_we = 1'b0;
        unique case (i_cfg_index)
            CFG_ENABLE: enable_we = i_cfg_we;
            default:    enable_we = 1'b0;
        endcase
    end

    assign en_flip = enable_we ? (r_enable ^ i_cfg_data[MASK_W-1:0]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= '0;
            r_delay    <= '0;
            r_interval <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLE:   r_enable   <= i_cfg_data[MASK_W-1:0];
                CFG_DELAY:    r_delay    <= i_cfg_data[TICK_W-1:0];
                CFG_INTERVAL: r_interval <= i_cfg_data[TICK_W-1:0];
                default:      ;
            endcase
        end
    end

    // Pipeline control: both registers move whenever the output register is free.
    assign advance    = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_in_vld || advance;
    assign step       = r_in_vld && advance && r_in.any_read;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // Input register captures each accepted poll transaction.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Button lanes; mask bits above the lane count stay cleared.
    for (genvar gi = 0; gi < MASK_W; gi++) begin : g_lane
        if (gi < NUM_BUTTONS) begin : g_used
            bar_lane u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_step     (step),
                .i_en_flip  (en_flip[gi]),
                .i_in       ('{press: r_in.press_edges[gi], held: r_in.held_bits[gi],
                               rel: r_in.release_edges[gi]}),
                .i_enable   (r_enable[gi]),
                .i_now      (r_in.now_ticks),
                .i_delay    (r_delay),
                .i_interval (r_interval),
                .o_next     (lane_next[gi])
            );
        end else begin : g_unused
            assign lane_next[gi] = '0;
        end
        assign n_pressed[gi]  = lane_next[gi].pressed;
        assign n_held[gi]     = lane_next[gi].held;
        assign n_released[gi] = lane_next[gi].released;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (r_in_vld && advance) begin
            r_out.pressed_mask  <= n_pressed;
            r_out.held_mask     <= n_held;
            r_out.released_mask <= n_released;
            r_out.status        <= !r_in.any_read;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

### rtl/bar_chk.sv
// Port-level checker for the button auto-repeat block, bound to the top level.
module bar_chk import bar_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input t_bar_out             o_out_data
);

    logic              out_acc;
    logic [MASK_W-1:0] r_last_pressed;
    logic [MASK_W-1:0] r_last_held;
    logic [MASK_W-1:0] r_last_released;

    assign out_acc = o_out_valid && i_out_ready;

    // Masks of the last delivered result; all flags are clear after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pressed  <= '0;
            r_last_held     <= '0;
            r_last_released <= '0;
        end else if (out_acc) begin
            r_last_pressed  <= o_out_data.pressed_mask;
            r_last_held     <= o_out_data.held_mask;
            r_last_released <= o_out_data.released_mask;
        end
    end

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // A poll with no controller read repeats the previous flags.
    a_no_read_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_out_data.status |->
            o_out_data.pressed_mask == r_last_pressed &&
            o_out_data.held_mask == r_last_held &&
            o_out_data.released_mask == r_last_released)
        else $error("flags changed on a poll with no controller read");

    // A button never reports held together with pressed or released.
    a_held_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.held_mask & (o_out_data.pressed_mask |
                                     o_out_data.released_mask)) == '0)
        else $error("held reported together with pressed or released");

    // The input side stalls only behind a waiting result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

endmodule

bind button_auto_repeat bar_chk u_bar_chk (.*);
